// ----- rtl/kmsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kmsd_pkg;

  // Field widths
  localparam int OPCODE_W  = 2;
  localparam int ROWS_W    = 4;
  localparam int COLS_W    = 2;
  localparam int NUM_COLS  = 4;
  localparam int KEY_W     = 7;
  localparam int DRIVE_W   = 4;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 16;

  // Reset values
  localparam logic [COUNT_W-1:0] THRESHOLD_RST = 4'd5;
  localparam logic [COLS_W-1:0]  COLUMN_RST    = 2'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd1;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_SCAN = 2'd0,
    OP_READ = 2'd1,
    OP_PEEK = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  // One accepted input word
  typedef struct packed {
    op_t               opcode;
    logic [ROWS_W-1:0] row_sample;
  } item_t;

  // One result word
  typedef struct packed {
    logic [KEY_W-1:0]   key_char;
    logic [DRIVE_W-1:0] column_drive;
  } result_t;

  // Key map, column-major: index is {column, row}
  function automatic logic [KEY_W-1:0] key_lookup(input logic [3:0] idx);
    logic [KEY_W-1:0] ch;
    case (idx)
      4'd0:    ch = 7'h31;  // 1
      4'd1:    ch = 7'h34;  // 4
      4'd2:    ch = 7'h37;  // 7
      4'd3:    ch = 7'h2A;  // *
      4'd4:    ch = 7'h32;  // 2
      4'd5:    ch = 7'h35;  // 5
      4'd6:    ch = 7'h38;  // 8
      4'd7:    ch = 7'h30;  // 0
      4'd8:    ch = 7'h33;  // 3
      4'd9:    ch = 7'h36;  // 6
      4'd10:   ch = 7'h39;  // 9
      4'd11:   ch = 7'h23;  // #
      4'd12:   ch = 7'h41;  // A
      4'd13:   ch = 7'h42;  // B
      4'd14:   ch = 7'h43;  // C
      4'd15:   ch = 7'h44;  // D
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kmsd_input_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmsd_input_reg (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  kmsd_pkg::item_t          in_item,
  input  wire                      advance,
  output logic                     stage_valid,
  output kmsd_pkg::item_t          stage_item
);
  import kmsd_pkg::*;

  // Take a new word when empty or when the held word moves on
  assign in_ready = !stage_valid || advance;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kmsd_scan_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmsd_scan_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              fire,
  input  kmsd_pkg::item_t                  item,
  input  wire                              cfg_wr_en,
  input  wire [kmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [kmsd_pkg::CFG_DAT_W-1:0]    cfg_wr_data,
  output kmsd_pkg::result_t                result
);
  import kmsd_pkg::*;

  logic [COLS_W-1:0]  active_column;
  logic [COLS_W-1:0]  active_column_next;
  logic [ROWS_W-1:0]  last_rows    [NUM_COLS];
  logic [COUNT_W-1:0] stable_count [NUM_COLS];
  logic [COUNT_W-1:0] debounce_threshold;
  logic [KEY_W-1:0]   accepted_key;
  logic [KEY_W-1:0]   accepted_key_next;
  logic [ROWS_W-1:0]  rows_cur;
  logic [COUNT_W-1:0] count_cur;
  logic               rows_match;
  logic               below_threshold;
  logic [1:0]         low_row;
  logic [KEY_W-1:0]   key_scan;
  logic [KEY_W-1:0]   key_out;
  logic               do_scan;

  assign do_scan         = fire && (item.opcode == OP_SCAN);
  assign rows_cur        = last_rows[active_column];
  assign count_cur       = stable_count[active_column];
  assign rows_match      = (item.row_sample == rows_cur);
  assign below_threshold = (count_cur < debounce_threshold);

  // Pick lowest pressed row
  always_comb begin
    if (item.row_sample[0]) begin
      low_row = 2'd0;
    end else if (item.row_sample[1]) begin
      low_row = 2'd1;
    end else if (item.row_sample[2]) begin
      low_row = 2'd2;
    end else begin
      low_row = 2'd3;
    end
  end

  // Key after a scan tick
  always_comb begin
    key_scan = accepted_key;
    if (rows_match && !below_threshold) begin
      if (item.row_sample != '0) begin
        key_scan = key_lookup({active_column, low_row});
      end else begin
        key_scan = '0;
      end
    end
  end

  // Result and next key per operation
  always_comb begin
    active_column_next = active_column;
    accepted_key_next  = accepted_key;
    key_out            = accepted_key;
    case (item.opcode)
      OP_SCAN: begin
        accepted_key_next  = key_scan;
        key_out            = key_scan;
        active_column_next = active_column + 2'd1;
      end
      OP_READ: begin
        accepted_key_next = '0;
      end
      default: begin
        accepted_key_next = accepted_key;
      end
    endcase
  end

  assign result.key_char     = key_out;
  assign result.column_drive = DRIVE_W'(1) << active_column_next;

  // Column pointer, key and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      active_column      <= COLUMN_RST;
      accepted_key       <= '0;
      debounce_threshold <= THRESHOLD_RST;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_START_COLUMN)) begin
        active_column <= cfg_wr_data[COLS_W-1:0] + 2'd3;
      end else if (fire) begin
        active_column <= active_column_next;
      end
      if (fire) begin
        accepted_key  <= accepted_key_next;
      end
      if (cfg_wr_en && (cfg_index == REG_DEBOUNCE)) begin
        debounce_threshold <= cfg_wr_data[COUNT_W-1:0];
      end
    end
  end

  // Per-column sample history and stability count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        last_rows[i]    <= '0;
        stable_count[i] <= '0;
      end
    end else if (do_scan) begin
      if (!rows_match) begin
        last_rows[active_column]    <= item.row_sample;
        stable_count[active_column] <= '0;
      end else if (below_threshold) begin
        stable_count[active_column] <= count_cur + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keypad_matrix_scan_debounce_unit.sv -----
// A word accepted on s_ is held in the input register and then the output register before it appears on m_.
// Throughput: one word per cycle while m_tready stays high; on a result stall the
// input register takes one more word only if it is empty, then s_tready drops until the stall ends.
// All per-word work is one short compare, increment and key lookup between them.
// Reset (rst, synchronous): column 0 active, no key, all counts and samples zero,
// debounce threshold 5, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_scan_debounce_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [kmsd_pkg::S_DATA_W-1:0]     s_tdata,    // opcode[1:0], row_sample[5:2]
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [kmsd_pkg::M_DATA_W-1:0]    m_tdata,    // key_char[6:0], column_drive[10:7]
  input  wire                              cfg_wr_en,
  input  wire [kmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [kmsd_pkg::CFG_DAT_W-1:0]    cfg_wr_data
);
  import kmsd_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  logic    fire;
  result_t result;
  result_t out_word;

  // Unpack input word
  assign in_item.opcode     = op_t'(s_tdata[1:0]);
  assign in_item.row_sample = s_tdata[5:2];

  // Output register can take a word
  assign advance = !m_tvalid || m_tready;
  assign fire    = stage_valid && advance;

  kmsd_input_reg u_input_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  kmsd_scan_core u_scan_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (stage_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .result      (result)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= stage_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= result;
    end
  end

  // Pack result word, pad with zeros
  assign m_tdata = {5'd0, out_word.column_drive, out_word.key_char};

`ifndef SYNTHESIS
  // Column drive is always one-hot on a valid result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[10:7]))
    else $error("column drive not one-hot");

  // Empty output side never blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // Padding bits stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:11] == 5'd0))
    else $error("nonzero padding in result word");

  // A taken result is replaced only by a new word
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !stage_valid) |=> !m_tvalid)
    else $error("result repeated");
`endif

endmodule

`default_nettype wire
